/* rtl/hcm_pkg.sv */
package hcm_pkg;

  // CORDIC and hue constants
  localparam int CordicSteps = 16;
  localparam int AccW = 27;
  localparam logic [14:0] HueFull = 15'd23040;
  localparam logic [14:0] HueHalf = 15'd11520;
  localparam logic [14:0] HueLowLimit = 15'd5760;
  // round(sqrt(3) * 2^14)
  localparam int Sqrt3Q14 = 28378;

  // pixel class codes
  localparam logic [1:0] ClsMarked = 2'd0;
  localparam logic [1:0] ClsMaybe = 2'd1;
  localparam logic [1:0] ClsPlain = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegHueCenter = 2'd0;
  localparam logic [1:0] RegSatCenter = 2'd1;
  localparam logic [1:0] RegMarkThr = 2'd2;
  localparam logic [1:0] RegMaybeThr = 2'd3;

  // arctangent table in 2^-16 degree
  function automatic logic [AccW-1:0] atan_q16(input logic [3:0] i);
    logic [AccW-1:0] v;
    case (i)
      4'd0: v = 27'd2949120;
      4'd1: v = 27'd1740967;
      4'd2: v = 27'd919879;
      4'd3: v = 27'd466945;
      4'd4: v = 27'd234379;
      4'd5: v = 27'd117304;
      4'd6: v = 27'd58666;
      4'd7: v = 27'd29335;
      4'd8: v = 27'd14668;
      4'd9: v = 27'd7334;
      4'd10: v = 27'd3667;
      4'd11: v = 27'd1833;
      4'd12: v = 27'd917;
      4'd13: v = 27'd458;
      4'd14: v = 27'd229;
      default: v = 27'd115;
    endcase
    return v;
  endfunction

endpackage

/* rtl/hsi_cell_color_marker.sv */
// Each pipeline stage holds at most one pixel.
// Throughput: one pixel per cycle; stages advance together, held by output stall.
// Stages: input prep, 16 CORDIC iterations with the saturation divider riding
// along, hue finish, scaled differences, squares, compare and output register.
// Reset (rst, synchronous): clears valid bits, loads default configuration.
module hsi_cell_color_marker
  import hcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pix_red,
  input  logic [7:0]  pix_green,
  input  logic [7:0]  pix_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [1:0]  pixel_class,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int XW = 32;
  localparam int NS = CordicSteps;
  // saturation restoring divider: 13 quotient bits, one per CORDIC stage until all are found
  localparam int QB = 13;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       grey;
  } pix_t;

  // configuration
  logic [14:0] hue_center;
  logic [12:0] sat_center;
  logic [13:0] mark_threshold;
  logic [13:0] maybe_threshold;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_center <= 15'd18974;
      sat_center <= 13'd883;
      mark_threshold <= 14'd369;
      maybe_threshold <= 14'd614;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegHueCenter: hue_center <= cfg_data[14:0];
        RegSatCenter: sat_center <= cfg_data[12:0];
        RegMarkThr: mark_threshold <= cfg_data[13:0];
        RegMaybeThr: maybe_threshold <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // global advance: whole pipe moves unless output is full and stalled
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv && !rst;

  // ---------------- stage 0: prep ----------------
  logic            v0;
  pix_t            p0;
  logic signed [XW-1:0] x0, y0;
  logic [AccW-1:0] a0;
  logic            y0z;
  logic            xpos0;
  logic [9:0]      num0;  // sum - 3*min, up to 510
  logic [9:0]      sum0;

  logic [7:0] lo_c, hi_c;
  logic signed [10:0] dx_c;
  logic signed [8:0]  dy_c;
  logic signed [XW-1:0] xi_c, yi_c;

  always_comb begin
    lo_c = pix_red;
    hi_c = pix_red;
    if (pix_green < lo_c) lo_c = pix_green;
    if (pix_blue < lo_c) lo_c = pix_blue;
    if (pix_green > hi_c) hi_c = pix_green;
    if (pix_blue > hi_c) hi_c = pix_blue;
    dx_c = 11'(signed'({3'b0, pix_red}) * 2) - 11'(signed'({3'b0, pix_green}))
           - 11'(signed'({3'b0, pix_blue}));
    dy_c = signed'({1'b0, pix_green}) - signed'({1'b0, pix_blue});
    xi_c = XW'(dx_c) <<< 14;
    yi_c = XW'(dy_c) * XW'(Sqrt3Q14);
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= in_valid;
    if (adv) begin
      p0 <= '{pix_red, pix_green, pix_blue, lo_c == hi_c};
      y0z <= (yi_c == '0);
      xpos0 <= (xi_c > 0);
      sum0 <= 10'(pix_red) + 10'(pix_green) + 10'(pix_blue);
      num0 <= 10'(pix_red) + 10'(pix_green) + 10'(pix_blue) - 10'(lo_c) * 10'd3;
      if (xi_c < 0) begin
        x0 <= -xi_c;
        y0 <= -yi_c;
        a0 <= AccW'(180 * 65536);
      end else begin
        x0 <= xi_c;
        y0 <= yi_c;
        a0 <= '0;
      end
    end
  end

  // ---------------- CORDIC stages 1..NS, divider riding along ----------------
  logic                 cv [NS+1];
  pix_t                 cp [NS+1];
  logic signed [XW-1:0] cx [NS+1];
  logic signed [XW-1:0] cy [NS+1];
  logic [AccW-1:0]      ca [NS+1];
  logic                 cyz [NS+1];
  logic                 cxp [NS+1];
  logic [9:0]           csum [NS+1];
  // remainder and quotient of (num*8192 + sum) / (2*sum)
  logic [23:0]          crem [NS+1];
  logic [QB-1:0]        cq [NS+1];

  assign cv[0] = v0;
  assign cp[0] = p0;
  assign cx[0] = x0;
  assign cy[0] = y0;
  assign ca[0] = a0;
  assign cyz[0] = y0z;
  assign cxp[0] = xpos0;
  assign csum[0] = sum0;
  assign crem[0] = {1'b0, num0, 13'd0} + 24'(sum0);
  assign cq[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    // quotient bit position handled by this stage
    localparam int QSh = (i < QB) ? (QB - 1 - i) : 0;
    logic signed [XW-1:0] xs, ys, xn, yn;
    logic [AccW-1:0] an;
    logic [23:0] rn;
    logic [QB-1:0] qn;
    logic [23:0] dsh;
    always_comb begin
      xs = cx[i] >>> i;
      ys = cy[i] >>> i;
      if (cy[i] > 0) begin
        xn = cx[i] + ys;
        yn = cy[i] - xs;
        an = ca[i] + atan_q16(4'(i));
      end else begin
        xn = cx[i] - ys;
        yn = cy[i] + xs;
        an = ca[i] - atan_q16(4'(i));
      end
      rn = crem[i];
      qn = cq[i];
      dsh = '0;
      if (i < QB) begin
        // divisor 2*sum shifted to quotient bit QB-1-i
        dsh = 24'({csum[i], 1'b0}) << QSh;
        if (crem[i] >= dsh) begin
          rn = crem[i] - dsh;
          qn = cq[i] | (QB'(1) << QSh);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (adv) cv[i+1] <= cv[i];
      if (adv) begin
        cp[i+1] <= cp[i];
        cx[i+1] <= xn;
        cy[i+1] <= yn;
        ca[i+1] <= an;
        cyz[i+1] <= cyz[i];
        cxp[i+1] <= cxp[i];
        csum[i+1] <= csum[i];
        crem[i+1] <= rn;
        cq[i+1] <= qn;
      end
    end
  end

  // ---------------- hue finish ----------------
  logic        v1;
  pix_t        p1;
  logic [14:0] hue1;
  logic [12:0] sat1;

  logic [AccW-1:0] tot_c;
  logic [AccW-1:0] hr_c;
  logic [14:0] h_c;
  always_comb begin
    tot_c = ca[NS];
    if (tot_c[AccW-1]) tot_c = tot_c + AccW'(360 * 65536);
    hr_c = (tot_c + AccW'(512)) >> 10;
    h_c = hr_c[14:0];
    if (h_c >= HueFull) h_c = h_c - HueFull;
    if (cyz[NS]) h_c = cxp[NS] ? 15'd0 : HueHalf;
    if (h_c < HueLowLimit) h_c = h_c + HueFull;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= cv[NS];
    if (adv) begin
      p1 <= cp[NS];
      hue1 <= h_c;
      sat1 <= cq[NS];
    end
  end

  // ---------------- scaled differences ----------------
  logic        v2;
  pix_t        p2;
  logic signed [20:0] dh2;   // 16*dh
  logic signed [19:0] ds2;   // 45*ds
  logic [19:0] tm2, tb2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      p2 <= p1;
      dh2 <= (21'(signed'({1'b0, hue1})) - 21'(signed'({1'b0, hue_center}))) <<< 4;
      ds2 <= (20'(signed'({1'b0, sat1})) - 20'(signed'({1'b0, sat_center}))) * 20'sd45;
      tm2 <= 20'(mark_threshold) * 20'd45;
      tb2 <= 20'(maybe_threshold) * 20'd45;
    end
  end

  // ---------------- squares ----------------
  logic        v3;
  pix_t        p3;
  logic [41:0] dh3, ds3;
  logic [39:0] tm3, tb3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      p3 <= p2;
      dh3 <= 42'(dh2 * dh2);
      ds3 <= 42'(ds2 * ds2);
      tm3 <= 40'(tm2) * 40'(tm2);
      tb3 <= 40'(tb2) * 40'(tb2);
    end
  end

  // ---------------- compare and output ----------------
  logic [42:0] d2_c;
  logic [1:0]  cls_c;
  logic [7:0]  or_c, og_c, ob_c;
  always_comb begin
    d2_c = 43'(dh3) + 43'(ds3);
    cls_c = ClsPlain;
    if (!p3.grey) begin
      if (d2_c < 43'(tm3)) cls_c = ClsMarked;
      else if (d2_c < 43'(tb3)) cls_c = ClsMaybe;
    end
    or_c = p3.r;
    og_c = p3.g;
    ob_c = p3.b;
    case (cls_c)
      ClsMarked: begin
        or_c = 8'd255; og_c = 8'd0; ob_c = 8'd0;
      end
      ClsMaybe: begin
        or_c = 8'd0; og_c = 8'd0; ob_c = 8'd255;
      end
      default: begin
        if (p3.b == 8'd0) ob_c = 8'd1;
        else if (p3.b == 8'd255) ob_c = 8'd254;
        else if (p3.r == 8'd128) or_c = 8'd127;
        if (p3.g == 8'd255) begin
          or_c = p3.r; og_c = 8'd254; ob_c = p3.b;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v3;
    if (adv) begin
      out_red <= or_c;
      out_green <= og_c;
      out_blue <= ob_c;
      pixel_class <= cls_c;
    end
  end

`ifndef NO_ASSERTIONS
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_class != 2'd3) else $error("bad class");
  a_marked_red: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_class == ClsMarked |-> out_red == 8'd255 && out_blue == 8'd0)
    else $error("marked not red");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_class))
    else $error("stall lost item");
  a_plain_green: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_class == ClsPlain |-> out_green != 8'd255)
    else $error("green not nudged");
`endif

endmodule
